### sv/ctwl_pkg.sv
package ctwl_pkg;

   localparam int POS_W    = 32;
   localparam int COORD_W  = 31;
   localparam int CODE_W   = 4;
   localparam int LEN_W    = 28;
   localparam int OFFSET_W = 34;  // holds -1 up to query_pos plus an edge gap
   localparam int STATUS_W = 2;
   localparam int ADDR_W   = 4;
   localparam int DATA_W   = 32;
   localparam int REQ_W    = 64;
   localparam int RSP_W    = 64;

   typedef enum logic [CODE_W-1:0] {
      OP_M = 4'd0,
      OP_I = 4'd1,
      OP_D = 4'd2,
      OP_N = 4'd3,
      OP_S = 4'd4,
      OP_H = 4'd5,
      OP_P = 4'd6,
      OP_EQ = 4'd7,
      OP_X = 4'd8
   } op_code_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 2'd0,
      ST_LATE_START  = 2'd1,
      ST_UNSUPPORTED = 2'd2,
      ST_EDGE_MISSING = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      REG_WINDOW_START = 2'd0,
      REG_WINDOW_END   = 2'd1,
      REG_PARTIAL_MODE = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [COORD_W-1:0] window_start;
      logic [COORD_W-1:0] window_end;
      logic               partial_mode;
   } cfg_type;

   typedef struct packed {
      logic               first_op;
      logic [COORD_W-1:0] align_pos;
      logic [CODE_W-1:0]  op_code;
      logic [LEN_W-1:0]   op_len;
      logic               last_op;
   } item_type;

   typedef struct packed {
      logic [POS_W-1:0]           query_pos;
      logic [POS_W-1:0]           ref_pos;
      logic                       start_found;
      logic                       end_found;
      logic signed [OFFSET_W-1:0] start_offset;
      logic signed [OFFSET_W-1:0] end_offset;
      status_type                 read_status;
   } walk_state_type;

endpackage

### sv/ctwl_csr.sv
module ctwl_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [ctwl_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [ctwl_pkg::DATA_W-1:0] csr_pwdata,
   output logic [ctwl_pkg::DATA_W-1:0] csr_prdata,
   output logic                        csr_pready,
   output ctwl_pkg::cfg_type           cfg
);

   ctwl_pkg::cfg_type cfg_ff, cfg_in;
   logic [1:0]        reg_sel;
   logic              wr_en;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[3:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            ctwl_pkg::REG_WINDOW_START: cfg_in.window_start = csr_pwdata[ctwl_pkg::COORD_W-1:0];
            ctwl_pkg::REG_WINDOW_END:   cfg_in.window_end   = csr_pwdata[ctwl_pkg::COORD_W-1:0];
            ctwl_pkg::REG_PARTIAL_MODE: cfg_in.partial_mode = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_start <= '0;
         cfg_ff.window_end   <= '0;
         cfg_ff.partial_mode <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_sel)
         ctwl_pkg::REG_WINDOW_START: csr_prdata = {1'b0, cfg_ff.window_start};
         ctwl_pkg::REG_WINDOW_END:   csr_prdata = {1'b0, cfg_ff.window_end};
         ctwl_pkg::REG_PARTIAL_MODE: csr_prdata = {31'd0, cfg_ff.partial_mode};
         default:                    csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

### sv/ctwl_step.sv
module ctwl_step (
   input  ctwl_pkg::cfg_type        cfg,
   input  ctwl_pkg::item_type       item,
   input  ctwl_pkg::walk_state_type cur,
   output ctwl_pkg::walk_state_type nxt
);

   ctwl_pkg::walk_state_type base;
   logic [ctwl_pkg::POS_W-1:0] len32;
   logic [ctwl_pkg::POS_W-1:0] tail_q;
   logic                       start_hit, end_hit;
   logic signed [ctwl_pkg::OFFSET_W-1:0] start_off, end_off;

   // First aligned base at or past the edge within this operation, closed form.
   function automatic logic seek_hit(input logic [ctwl_pkg::COORD_W-1:0] edge_pos,
                                     input logic [ctwl_pkg::POS_W-1:0] rp,
                                     input logic [ctwl_pkg::POS_W-1:0] len);
      logic [ctwl_pkg::POS_W-1:0] e32;
      e32 = {1'b0, edge_pos};
      seek_hit = (rp > e32) || ((e32 - rp) < len);
   endfunction

   function automatic logic signed [ctwl_pkg::OFFSET_W-1:0] seek_off(
      input logic [ctwl_pkg::COORD_W-1:0] edge_pos,
      input logic [ctwl_pkg::POS_W-1:0] rp,
      input logic [ctwl_pkg::POS_W-1:0] qp);
      logic [ctwl_pkg::POS_W-1:0] e32;
      logic signed [ctwl_pkg::OFFSET_W-1:0] qx;
      e32 = {1'b0, edge_pos};
      qx  = signed'({2'b00, qp});
      if (rp > e32) begin
         seek_off = qx - ctwl_pkg::OFFSET_W'(1);  // edge overshot
      end else begin
         seek_off = qx + signed'({2'b00, e32 - rp});
      end
   endfunction

   assign len32 = {{(ctwl_pkg::POS_W-ctwl_pkg::LEN_W){1'b0}}, item.op_len};

   always_comb begin
      base = cur;
      if (item.first_op) begin
         base.query_pos    = '0;
         base.ref_pos      = {1'b0, item.align_pos};
         base.start_found  = 1'b0;
         base.end_found    = 1'b0;
         base.start_offset = '1;
         base.end_offset   = '1;
         base.read_status  = ctwl_pkg::ST_OK;
         if (item.align_pos > cfg.window_start) begin
            if (cfg.partial_mode) begin
               base.start_offset = '0;
               base.start_found  = 1'b1;
            end else begin
               base.read_status = ctwl_pkg::ST_LATE_START;
            end
         end
      end
   end

   assign start_hit = !base.start_found && (item.op_len != '0)
                      && seek_hit(cfg.window_start, base.ref_pos, len32);
   assign end_hit   = !base.end_found && (item.op_len != '0)
                      && seek_hit(cfg.window_end, base.ref_pos, len32);
   assign start_off = seek_off(cfg.window_start, base.ref_pos, base.query_pos);
   assign end_off   = seek_off(cfg.window_end, base.ref_pos, base.query_pos);

   always_comb begin
      nxt    = base;
      tail_q = '0;
      if (base.read_status == ctwl_pkg::ST_OK) begin
         case (item.op_code)
            ctwl_pkg::OP_M, ctwl_pkg::OP_EQ, ctwl_pkg::OP_X: begin
               if (start_hit) begin
                  nxt.start_found  = 1'b1;
                  nxt.start_offset = start_off;
               end
               if (end_hit) begin
                  nxt.end_found  = 1'b1;
                  nxt.end_offset = end_off;
               end
               nxt.query_pos = base.query_pos + len32;
               nxt.ref_pos   = base.ref_pos + len32;
            end
            ctwl_pkg::OP_D: nxt.ref_pos = base.ref_pos + len32;
            ctwl_pkg::OP_I, ctwl_pkg::OP_S: nxt.query_pos = base.query_pos + len32;
            ctwl_pkg::OP_H: ;
            default: nxt.read_status = ctwl_pkg::ST_UNSUPPORTED;
         endcase
         // missing end in partial mode: query length less a trailing soft clip
         if (item.last_op && (nxt.read_status == ctwl_pkg::ST_OK) && !nxt.end_found
             && cfg.partial_mode) begin
            tail_q = (item.op_code == ctwl_pkg::OP_S) ? base.query_pos : nxt.query_pos;
            nxt.end_offset = signed'({2'b00, tail_q});
            nxt.end_found  = 1'b1;
         end
      end
   end

endmodule

### sv/cigar_window_trim_locator_top.sv
// Path: an accepted item is registered in the item register, which feeds the walk
// step; the step loads the result register when the last item fires from that stage.
// Throughput: one item per cycle; the running positions close a loop through the walk
// state register and the step logic, and a stalled result stops the walk only at a last item.
// Reset (synchronous, active high) clears the walk state, empties both stages
// and loads the register reset values.
module cigar_window_trim_locator_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [ctwl_pkg::REQ_W-1:0]  req_tdata,  // align_pos, op_code, op_len, zero pad
   input  logic                        req_tuser,  // first_op
   input  logic                        req_tlast,  // last_op
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [ctwl_pkg::RSP_W-1:0]  rsp_tdata,  // query_start, query_end
   output logic [2:0]                  rsp_tuser,  // trim_status, keep_read
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [ctwl_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [ctwl_pkg::DATA_W-1:0] csr_pwdata,
   output logic [ctwl_pkg::DATA_W-1:0] csr_prdata,
   output logic                        csr_pready
);

   ctwl_pkg::cfg_type        cfg;
   ctwl_pkg::item_type       item_ff, item_in;
   logic                     s1_valid_ff, s1_valid_in;
   logic                     s1_fire;
   ctwl_pkg::walk_state_type walk_ff, walk_nxt;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [ctwl_pkg::OFFSET_W-1:0] rsp_start_ff, rsp_start_in;
   logic signed [ctwl_pkg::OFFSET_W-1:0] rsp_end_ff, rsp_end_in;
   ctwl_pkg::status_type     rsp_status_ff, rsp_status_in;
   ctwl_pkg::status_type     fin_status;
   logic signed [ctwl_pkg::OFFSET_W:0] diff;
   logic                     keep;

   ctwl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ctwl_step u_step (
      .cfg  (cfg),
      .item (item_ff),
      .cur  (walk_ff),
      .nxt  (walk_nxt)
   );

   // a last item needs the result slot to be free or draining
   assign s1_fire    = s1_valid_ff && (!item_ff.last_op || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_fire;

   always_comb begin
      item_in     = item_ff;
      s1_valid_in = s1_valid_ff && !s1_fire;
      if (req_tvalid && req_tready) begin
         item_in.first_op  = req_tuser;
         item_in.align_pos = req_tdata[30:0];
         item_in.op_code   = req_tdata[34:31];
         item_in.op_len    = req_tdata[62:35];
         item_in.last_op   = req_tlast;
         s1_valid_in       = 1'b1;
      end
   end

   always_comb begin
      fin_status = walk_nxt.read_status;
      if (fin_status == ctwl_pkg::ST_OK
          && (walk_nxt.start_offset < 0 || walk_nxt.end_offset < 0)) begin
         fin_status = ctwl_pkg::ST_EDGE_MISSING;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_start_in  = rsp_start_ff;
      rsp_end_in    = rsp_end_ff;
      rsp_status_in = rsp_status_ff;
      if (s1_fire && item_ff.last_op) begin
         rsp_valid_in  = 1'b1;
         rsp_start_in  = walk_nxt.start_offset;
         rsp_end_in    = walk_nxt.end_offset;
         rsp_status_in = fin_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff          <= 1'b0;
         rsp_valid_ff         <= 1'b0;
         walk_ff.query_pos    <= '0;
         walk_ff.ref_pos      <= '0;
         walk_ff.start_found  <= 1'b0;
         walk_ff.end_found    <= 1'b0;
         walk_ff.start_offset <= '1;
         walk_ff.end_offset   <= '1;
         walk_ff.read_status  <= ctwl_pkg::ST_OK;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_fire) begin
            walk_ff <= walk_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_end_ff    <= rsp_end_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign diff = {rsp_end_ff[ctwl_pkg::OFFSET_W-1], rsp_end_ff}
               - {rsp_start_ff[ctwl_pkg::OFFSET_W-1], rsp_start_ff};
   assign keep = (rsp_status_ff == ctwl_pkg::ST_OK) && (diff > 1);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_end_ff[31:0], rsp_start_ff[31:0]};
   assign rsp_tuser  = {keep, rsp_status_ff};

endmodule

### sv/ctwl_checker.sv
module ctwl_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic [ctwl_pkg::REQ_W-1:0]  req_tdata,
   input logic                        req_tuser,
   input logic                        req_tlast,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [ctwl_pkg::RSP_W-1:0]  rsp_tdata,
   input logic [2:0]                  rsp_tuser,
   input logic                        csr_psel,
   input logic                        csr_penable,
   input logic                        csr_pwrite,
   input logic [ctwl_pkg::ADDR_W-1:0] csr_paddr,
   input logic [ctwl_pkg::DATA_W-1:0] csr_pwdata,
   input logic [ctwl_pkg::DATA_W-1:0] csr_prdata,
   input logic                        csr_pready
);

   logic [1:0] rd_sel;
   assign rd_sel = csr_paddr[3:2];

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_keep_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[2]) |-> (rsp_tuser[1:0] == ctwl_pkg::ST_OK))
      else $error("keep flag on a read that is not ok");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)
                                        && $stable(rsp_tuser)))
      else $error("stalled result changed");

   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite && csr_pready
       && rd_sel == ctwl_pkg::REG_WINDOW_START)
      |=> ((rd_sel != ctwl_pkg::REG_WINDOW_START) || csr_pwrite
           || (csr_prdata[30:0] == $past(csr_pwdata[30:0]))))
      else $error("window start readback mismatch");

endmodule

bind cigar_window_trim_locator_top ctwl_checker u_ctwl_checker (.*);

### bench/testbench.sv
import ctwl_pkg::*;

typedef struct {
   bit [31:0]  q_start;
   bit [31:0]  q_end;
   status_type status;
   bit         keep;
} trim_result_type;

// Tracks one read's walk and queues the trim offsets each last op should report
class trim_offset_tracker;
   bit [30:0]       win_start;
   bit [30:0]       win_end;
   bit              partial;
   bit [31:0]       query_pos;
   bit [31:0]       ref_pos;
   bit              start_hit;
   bit              end_hit;
   longint          start_off;
   longint          end_off;
   status_type      walk_status;
   trim_result_type pending_trims[$];
   int              faults;

   function new();
      win_start   = 0;
      win_end     = 0;
      partial     = 1'b1;
      query_pos   = 0;
      ref_pos     = 0;
      start_hit   = 1'b0;
      end_hit     = 1'b0;
      start_off   = -1;
      end_off     = -1;
      walk_status = ST_OK;
      faults      = 0;
   endfunction

   function void set_reg(input reg_index_type idx, input bit [31:0] value);
      case (idx)
         REG_WINDOW_START: win_start = value[30:0];
         REG_WINDOW_END:   win_end = value[30:0];
         REG_PARTIAL_MODE: partial = value[0];
         default: ;
      endcase
   endfunction

   function int pending();
      return pending_trims.size();
   endfunction

   function void fault(input string msg);
      faults++;
      if (faults <= 10) $display("mismatch: %s", msg);
   endfunction

   // first aligned base at or past the edge within this op, closed form
   function void seek(input bit [31:0] edge_pos, input bit [31:0] len,
                      inout bit hit, inout longint off);
      if (hit || len == 0) return;
      if (ref_pos > edge_pos) begin
         off = longint'({32'd0, query_pos}) - 1;
         hit = 1'b1;
      end else if ((edge_pos - ref_pos) < len) begin
         off = longint'({32'd0, query_pos}) + longint'({32'd0, edge_pos - ref_pos});
         hit = 1'b1;
      end
   endfunction

   function void take_op(input item_type op);
      bit [31:0]       len;
      bit [31:0]       q;
      status_type      st;
      longint          span;
      trim_result_type res;
      len = {4'd0, op.op_len};
      if (op.first_op) begin
         query_pos   = 0;
         ref_pos     = {1'b0, op.align_pos};
         start_hit   = 1'b0;
         end_hit     = 1'b0;
         start_off   = -1;
         end_off     = -1;
         walk_status = ST_OK;
         if (op.align_pos > win_start) begin
            if (partial) begin
               start_off = 0;
               start_hit = 1'b1;
            end else begin
               walk_status = ST_LATE_START;
            end
         end
      end
      if (walk_status == ST_OK) begin
         case (op.op_code)
            OP_M, OP_EQ, OP_X: begin
               seek({1'b0, win_start}, len, start_hit, start_off);
               seek({1'b0, win_end}, len, end_hit, end_off);
               query_pos += len;
               ref_pos   += len;
            end
            OP_D: ref_pos += len;
            OP_I, OP_S: query_pos += len;
            OP_H: ;
            default: walk_status = ST_UNSUPPORTED;
         endcase
         // partial mode: a missing end falls back to the query length less trailing clip
         if (op.last_op && walk_status == ST_OK && !end_hit && partial) begin
            q = query_pos;
            if (op.op_code == OP_S) q -= len;
            end_off = longint'({32'd0, q});
            end_hit = 1'b1;
         end
      end
      if (!op.last_op) return;
      st = walk_status;
      if (st == ST_OK && (start_off < 0 || end_off < 0)) st = ST_EDGE_MISSING;
      span        = end_off - start_off;
      res.q_start = start_off[31:0];
      res.q_end   = end_off[31:0];
      res.status  = st;
      res.keep    = (st == ST_OK && span > 1);
      pending_trims.push_back(res);
   endfunction

   function void match_result(input logic [63:0] data, input logic [2:0] user);
      trim_result_type want;
      if (pending_trims.size() == 0) begin
         fault($sformatf("unexpected result start %0d end %0d status %0d keep %b",
                         $signed(data[31:0]), $signed(data[63:32]), user[1:0], user[2]));
         return;
      end
      want = pending_trims.pop_front();
      if (data[31:0] !== want.q_start || data[63:32] !== want.q_end ||
          user[1:0] !== want.status || user[2] !== want.keep)
         fault($sformatf("start %0d end %0d status %0d keep %b, want %0d %0d %0d %b",
                         $signed(data[31:0]), $signed(data[63:32]), user[1:0], user[2],
                         $signed(want.q_start), $signed(want.q_end), want.status,
                         want.keep));
   endfunction
endclass

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_OPS   = 46;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [REQ_W-1:0]    req_tdata;  // align_pos, op_code, op_len, zero pad
   logic                req_tuser;  // first_op
   logic                req_tlast;  // last_op
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RSP_W-1:0]    rsp_tdata;  // query_start, query_end
   logic [2:0]          rsp_tuser;  // trim_status, keep_read
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [ADDR_W-1:0]   csr_paddr;
   logic [DATA_W-1:0]   csr_pwdata;
   logic [DATA_W-1:0]   csr_prdata;
   logic                csr_pready;

   trim_offset_tracker tracker = new();
   item_type           seen_op;
   bit                 tx_quiet = 1'b0;
   bit                 rx_quiet = 1'b0;
   bit                 hold_request = 1'b0;
   int                 op_count = 0;
   int                 quiet_cycles = 0;

   cigar_window_trim_locator_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            seen_op.first_op  = req_tuser;
            seen_op.align_pos = req_tdata[30:0];
            seen_op.op_code   = req_tdata[34:31];
            seen_op.op_len    = req_tdata[62:35];
            seen_op.last_op   = req_tlast;
            tracker.take_op(seen_op);
         end
         if (rsp_tvalid && rsp_tready) tracker.match_result(rsp_tdata, rsp_tuser);
      end
   end

   initial begin
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic int pick_gap(input bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready   = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else begin
            rsp_tready = 1'b1;
            if (!rx_quiet && $urandom_range(0, 3) == 0) stall_left = pick_gap(1'b0);
         end
         @(negedge clock);
      end
   end

   task automatic send_op(input bit first, input bit [30:0] pos, input bit [3:0] code,
                          input bit [27:0] len, input bit last);
      int gap;
      gap = pick_gap(tx_quiet);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {1'b0, len, code, pos};
      req_tuser  = first;
      req_tlast  = last;
      do @(posedge clock); while (!req_tready);
   endtask

   // write a register, then read it back
   task automatic program_reg(input reg_index_type idx, input bit [31:0] value);
      logic [31:0] got;
      logic [31:0] want;
      want = (idx == REG_PARTIAL_MODE) ? {31'd0, value[0]} : {1'b0, value[30:0]};
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.set_reg(idx, value);
      @(negedge clock);
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      if (got !== want)
         tracker.fault($sformatf("register %s reads %0h, want %0h", idx.name(), got, want));
   endtask

   task automatic settle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      // non-last ops may still be in the pipe
      repeat (8) @(posedge clock);
   endtask

   function automatic bit [30:0] pick_pos();
      int        r;
      int        off;
      bit [31:0] t;
      r = $urandom_range(0, 15);
      if (r == 0) return 31'($urandom());
      if (r < 3) begin
         t = {1'b0, tracker.win_start} + $urandom_range(1, 60);
         return (t > 32'h7fffffff) ? 31'h7fffffff : t[30:0];
      end
      off = $urandom_range(0, 400);
      return (tracker.win_start > off) ? tracker.win_start - 31'(off) : 31'd0;
   endfunction

   function automatic bit [27:0] pick_len();
      int r;
      r = $urandom_range(0, 39);
      if (r == 0) return 28'd0;
      if (r == 1) return 28'($urandom_range(0, 28'hfffffff));
      return 28'($urandom_range(1, 150));
   endfunction

   task automatic walk_random_read();
      int        n;
      int        r;
      bit        well;
      bit        big;
      bit        first;
      bit        last;
      bit [30:0] pos;
      bit [3:0]  code;
      bit [27:0] len;
      well = ($urandom_range(0, 4) != 0);
      // rare long read with huge ops so the positions wrap
      big  = ($urandom_range(0, 39) == 0);
      n    = big ? $urandom_range(17, 20) : $urandom_range(1, 7);
      for (int i = 0; i < n; i++) begin
         first = (i == 0);
         last  = (i == n - 1);
         pos   = first ? pick_pos() : 31'($urandom());
         r     = $urandom_range(0, 9);
         if (big) begin
            code = (i % 3 == 0) ? OP_M : OP_I;
            len  = 28'hfffffff - 28'($urandom_range(0, 255));
         end else begin
            len = pick_len();
            if ((first || last) && n > 1 && r < 3)
               code = (r == 0) ? OP_H : OP_S;
            else
               case (r)
                  0, 1, 2, 3: code = OP_M;
                  4: code = OP_EQ;
                  5: code = OP_X;
                  6: code = OP_I;
                  7: code = OP_D;
                  8: code = OP_S;
                  default: code = OP_H;
               endcase
         end
         if (!well) begin
            if ($urandom_range(0, 4) == 0) code = 4'($urandom_range(0, 15));
            if ($urandom_range(0, 7) == 0) first = !first;
            if ($urandom_range(0, 7) == 0) last = !last;
         end
         send_op(first, pos, code, len, last);
      end
      if (well) op_count += n;
   endtask

   initial begin
      bit [30:0] ws;
      bit [30:0] we;
      bit        pm;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      req_tlast   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      program_reg(REG_WINDOW_START, 32'd100);
      program_reg(REG_WINDOW_END, 32'd200);
      program_reg(REG_PARTIAL_MODE, 32'd1);
      send_op(1, 31'd50, OP_M, 28'd300, 1);
      send_op(1, 31'd0, OP_S, 28'd10, 0);
      send_op(0, 31'd0, OP_M, 28'd150, 0);
      send_op(0, 31'd0, OP_I, 28'd5, 0);
      send_op(0, 31'd0, OP_D, 28'd20, 0);
      send_op(0, 31'd0, OP_EQ, 28'd50, 0);
      send_op(0, 31'd0, OP_X, 28'd40, 0);
      send_op(0, 31'd0, OP_H, 28'd3, 1);
      // late start, partial: query start pinned at 0
      send_op(1, 31'd150, OP_M, 28'd100, 1);
      // skip aborts after the start was found
      send_op(1, 31'd90, OP_M, 28'd20, 0);
      send_op(0, 31'd0, OP_N, 28'd5, 0);
      send_op(0, 31'd0, OP_M, 28'd100, 1);
      send_op(1, 31'd90, OP_P, 28'd4, 1);
      send_op(1, 31'd0, 4'hf, 28'd8, 1);
      // end missing, trailing soft clip taken off
      send_op(1, 31'd90, OP_M, 28'd30, 0);
      send_op(0, 31'd0, OP_S, 28'd7, 1);
      // overshoot at query 0 gives -1, plus an empty op
      send_op(1, 31'd90, OP_D, 28'd20, 0);
      send_op(0, 31'd0, OP_M, 28'd0, 0);
      send_op(0, 31'd0, OP_M, 28'd200, 1);
      // no first mark: walk continues from the previous read
      send_op(0, 31'd0, OP_M, 28'd10, 1);
      send_op(1, 31'h7fffffff, OP_M, 28'hfffffff, 1);
      settle();

      program_reg(REG_PARTIAL_MODE, 32'd0);
      send_op(1, 31'd150, OP_M, 28'd100, 1);
      send_op(1, 31'd90, OP_M, 28'd30, 0);
      send_op(0, 31'd0, OP_S, 28'd7, 1);
      settle();

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: begin ws = 31'd0; we = 31'd0; pm = 1'b1; end
            1: begin ws = 31'h7fffffff; we = 31'h7fffffff; pm = 1'b0; end
            2: begin ws = 31'd0; we = 31'h7fffffff; pm = 1'b1; end
            7: begin ws = 31'($urandom()); we = 31'($urandom()); pm = 1'b1; end
            default: begin
               ws = 31'($urandom_range(0, 2000));
               we = ($urandom_range(0, 5) == 0) ? 31'($urandom_range(0, 2000))
                                                : ws + 31'($urandom_range(0, 800));
               pm = 1'($urandom_range(0, 1));
            end
         endcase
         // junk in the unused top bit must be dropped
         program_reg(REG_WINDOW_START, {1'($urandom_range(0, 1)), ws});
         program_reg(REG_WINDOW_END, {1'($urandom_range(0, 1)), we});
         program_reg(REG_PARTIAL_MODE, {31'($urandom()), pm});
         tx_quiet = (p == 3 || p == 5);
         rx_quiet = (p == 5);
         // receiver holds off while the sender keeps pushing, block backs up
         if (p == 3) hold_request = 1'b1;
         op_count = 0;
         while (op_count < PHASE_OPS) walk_random_read();
         settle();
      end

      repeat (10) @(posedge clock);
      if (tracker.faults == 0 && tracker.pending() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
